// ----- hdl/cqs_pkg.sv -----
// shared types and codes for the circular queue with search
`default_nettype none
package cqs_pkg;

   localparam int DATA_W = 32;

   localparam logic [1:0] FUNC_ENQ  = 2'd0;
   localparam logic [1:0] FUNC_DEQ  = 2'd1;
   localparam logic [1:0] FUNC_SRCH = 2'd2;
   localparam logic [1:0] FUNC_NOP  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // broadcast from the control logic to every cell
   typedef struct packed {
      logic              wr_en;
      logic              is_deq;
      logic [DATA_W-1:0] data;
   } ctrl_type;

   // walking token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              hit_hi;
      logic              hit_lo;
      logic [DATA_W-1:0] value;
   } link_type;

endpackage
`default_nettype wire

// ----- hdl/cqs_cell.sv -----
// one queue slot with its compare logic and one stage of the walking token
`default_nettype none
module cqs_cell #(
   parameter int DEPTH = 8,
   parameter int INDEX = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cqs_pkg::ctrl_type            ctrl,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_slot,
   input  wire logic [$clog2(DEPTH)-1:0]     head,
   input  wire logic [$clog2(DEPTH+1)-1:0]   fill,
   input  wire cqs_pkg::link_type            prev_link,
   input  wire logic [$clog2(DEPTH)-1:0]     prev_pos_hi,
   input  wire logic [$clog2(DEPTH)-1:0]     prev_pos_lo,
   output cqs_pkg::link_type                 next_link,
   output logic [$clog2(DEPTH)-1:0]          next_pos_hi,
   output logic [$clog2(DEPTH)-1:0]          next_pos_lo
);

   localparam int IW = $clog2(DEPTH);
   localparam int OW = IW + 1;
   localparam logic [OW-1:0] IDX_W = OW'(INDEX);
   localparam logic [OW-1:0] DEP_W = OW'(DEPTH);
   localparam logic [IW-1:0] IDX_S = IW'(INDEX);

   logic [cqs_pkg::DATA_W-1:0] slot_ff;
   cqs_pkg::link_type          link_ff, link_in;
   logic [IW-1:0]              pos_hi_ff, pos_hi_in;
   logic [IW-1:0]              pos_lo_ff, pos_lo_in;
   logic [OW-1:0]              head_w;
   logic [OW-1:0]              offset;
   logic                       at_hi;
   logic                       occupied;
   logic                       hit;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en && (wr_slot == IDX_S)) begin
         slot_ff <= ctrl.data;
      end
   end

   // slots at or above head come first in queue order, wrapped slots after
   always_comb begin
      head_w   = {1'b0, head};
      at_hi    = (IDX_W >= head_w);
      offset   = at_hi ? (IDX_W - head_w) : (IDX_W + DEP_W - head_w);
      occupied = (offset < OW'(fill));
      hit      = occupied && (ctrl.is_deq ? (IDX_S == head) : (slot_ff == ctrl.data));
   end

   always_comb begin
      link_in   = prev_link;
      pos_hi_in = prev_pos_hi;
      pos_lo_in = prev_pos_lo;
      if (prev_link.valid && hit) begin
         if (at_hi && !prev_link.hit_hi) begin
            link_in.hit_hi = 1'b1;
            pos_hi_in      = IDX_S;
            if (ctrl.is_deq) begin
               link_in.value = slot_ff;
            end
         end else if (!at_hi && !prev_link.hit_lo) begin
            link_in.hit_lo = 1'b1;
            pos_lo_in      = IDX_S;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
      end
      link_ff.hit_hi <= link_in.hit_hi;
      link_ff.hit_lo <= link_in.hit_lo;
      link_ff.value  <= link_in.value;
      pos_hi_ff      <= pos_hi_in;
      pos_lo_ff      <= pos_lo_in;
   end

   assign next_link   = link_ff;
   assign next_pos_hi = pos_hi_ff;
   assign next_pos_lo = pos_lo_ff;

endmodule
`default_nettype wire

// ----- hdl/circular_queue_with_search_unit.sv -----
// circular queue of signed words with search: a row of DEPTH slot cells walked by a token
// enqueue, op code 3 and full/empty refusals pass the done register, then the output register to rsp_valid
// dequeue and search first pass the launch register and every cell register (token walks all cells)
// requests stall while a walk is in progress or the done register holds a result;
// a new item is taken while the previous result waits in the output register
// reset: synchronous, clears head, tail, fill and all valids; slot contents are left as they are
`default_nettype none
module circular_queue_with_search_unit #(
   parameter int DEPTH = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_func,
   input  wire logic signed [31:0]             req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic signed [31:0]                  rsp_value,
   output logic [$clog2(DEPTH)-1:0]            rsp_position,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   logic [IW-1:0]              head_ff, head_in;
   logic [IW-1:0]              tail_ff, tail_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [cqs_pkg::DATA_W-1:0] data_ff, data_in;
   logic                       wr_en_ff, wr_en_in;
   logic [IW-1:0]              wr_slot_ff, wr_slot_in;
   logic                       walk_ff, walk_in;
   logic                       launch_ff, launch_in;
   logic                       is_deq_ff, is_deq_in;
   logic [IW-1:0]              walk_head_ff, walk_head_in;
   logic [CW-1:0]              walk_fill_ff, walk_fill_in;
   logic                       done_valid_ff, done_valid_in;
   logic [1:0]                 done_status_ff, done_status_in;
   logic [cqs_pkg::DATA_W-1:0] done_value_ff, done_value_in;
   logic [IW-1:0]              done_pos_ff, done_pos_in;
   logic [CW-1:0]              done_count_ff, done_count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [cqs_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [IW-1:0]              rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0]              rsp_count_ff, rsp_count_in;

   logic                       req_fire;
   logic                       rsp_free;
   cqs_pkg::ctrl_type          ctrl;
   cqs_pkg::link_type          chain_link [DEPTH+1];
   logic [IW-1:0]              chain_pos_hi [DEPTH+1];
   logic [IW-1:0]              chain_pos_lo [DEPTH+1];
   cqs_pkg::link_type          exit_link;

   assign ctrl = '{wr_en: wr_en_ff, is_deq: is_deq_ff, data: data_ff};

   assign chain_link[0]   = '{valid: launch_ff, hit_hi: 1'b0, hit_lo: 1'b0, value: '0};
   assign chain_pos_hi[0] = '0;
   assign chain_pos_lo[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cqs_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .wr_slot     (wr_slot_ff),
         .head        (walk_head_ff),
         .fill        (walk_fill_ff),
         .prev_link   (chain_link[i]),
         .prev_pos_hi (chain_pos_hi[i]),
         .prev_pos_lo (chain_pos_lo[i]),
         .next_link   (chain_link[i+1]),
         .next_pos_hi (chain_pos_hi[i+1]),
         .next_pos_lo (chain_pos_lo[i+1])
      );
   end

   assign exit_link = chain_link[DEPTH];

   assign req_stall = walk_ff || done_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      data_in        = data_ff;
      wr_en_in       = 1'b0;
      wr_slot_in     = wr_slot_ff;
      walk_in        = walk_ff;
      launch_in      = 1'b0;
      is_deq_in      = is_deq_ff;
      walk_head_in   = walk_head_ff;
      walk_fill_in   = walk_fill_ff;
      done_valid_in  = done_valid_ff;
      done_status_in = done_status_ff;
      done_value_in  = done_value_ff;
      done_pos_in    = done_pos_ff;
      done_count_in  = done_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_count_in   = rsp_count_ff;

      // skid stage to output register
      if (rsp_free) begin
         rsp_valid_in  = done_valid_ff;
         rsp_status_in = done_status_ff;
         rsp_value_in  = done_value_ff;
         rsp_pos_in    = done_pos_ff;
         rsp_count_in  = done_count_ff;
         done_valid_in = 1'b0;
      end

      // token left the last cell
      if (exit_link.valid) begin
         walk_in       = 1'b0;
         done_valid_in = 1'b1;
         done_value_in = exit_link.value;
         if (exit_link.hit_hi) begin
            done_status_in = cqs_pkg::ST_OK;
            // a dequeue reports the word only, position stays zero
            done_pos_in    = is_deq_ff ? '0 : chain_pos_hi[DEPTH];
         end else if (exit_link.hit_lo) begin
            done_status_in = cqs_pkg::ST_OK;
            done_pos_in    = chain_pos_lo[DEPTH];
         end else begin
            done_status_in = cqs_pkg::ST_NOTFOUND;
            done_pos_in    = '0;
         end
      end

      if (req_fire) begin
         data_in        = $unsigned(req_data);
         walk_head_in   = head_ff;
         walk_fill_in   = fill_ff;
         done_status_in = cqs_pkg::ST_OK;
         done_value_in  = '0;
         done_pos_in    = '0;
         case (req_func)
            cqs_pkg::FUNC_ENQ: begin
               done_valid_in = 1'b1;
               if (fill_ff == FULL_CNT) begin
                  done_status_in = cqs_pkg::ST_FULL;
               end else begin
                  wr_en_in   = 1'b1;
                  wr_slot_in = tail_ff;
                  tail_in    = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
                  fill_in    = fill_ff + 1'b1;
               end
            end
            cqs_pkg::FUNC_DEQ: begin
               if (fill_ff == '0) begin
                  done_valid_in  = 1'b1;
                  done_status_in = cqs_pkg::ST_EMPTY;
               end else begin
                  walk_in   = 1'b1;
                  launch_in = 1'b1;
                  is_deq_in = 1'b1;
                  fill_in   = fill_ff - 1'b1;
                  // last entry gone: both pointers return to slot zero
                  if (fill_ff == CW'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
                  end
               end
            end
            cqs_pkg::FUNC_SRCH: begin
               if (fill_ff == '0) begin
                  done_valid_in  = 1'b1;
                  done_status_in = cqs_pkg::ST_EMPTY;
               end else begin
                  walk_in   = 1'b1;
                  launch_in = 1'b1;
                  is_deq_in = 1'b0;
               end
            end
            default: begin
               done_valid_in = 1'b1;
            end
         endcase
         done_count_in = fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         wr_en_ff      <= 1'b0;
         walk_ff       <= 1'b0;
         launch_ff     <= 1'b0;
         done_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         wr_en_ff      <= wr_en_in;
         walk_ff       <= walk_in;
         launch_ff     <= launch_in;
         done_valid_ff <= done_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      data_ff        <= data_in;
      wr_slot_ff     <= wr_slot_in;
      is_deq_ff      <= is_deq_in;
      walk_head_ff   <= walk_head_in;
      walk_fill_ff   <= walk_fill_in;
      done_status_ff <= done_status_in;
      done_value_ff  <= done_value_in;
      done_pos_ff    <= done_pos_in;
      done_count_ff  <= done_count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_value    = $signed(rsp_value_ff);
   assign rsp_position = rsp_pos_ff;
   assign rsp_count    = rsp_count_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("queue fill above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with pointers off slot zero");

   a_exit_in_walk: assert property (@(posedge clock) disable iff (reset)
      exit_link.valid |-> (walk_ff && !done_valid_ff))
      else $error("token left the chain with no walk pending");

   a_walk_holds_out: assert property (@(posedge clock) disable iff (reset)
      (walk_ff && !exit_link.valid) |=> req_stall)
      else $error("transfer taken while a walk is in progress");
`endif

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the circular queue with search
`default_nettype none
module testbench;

   localparam int DEPTH       = 8;
   localparam int POS_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int HOLD_CYCLES = 250;
   localparam int RANDOM_OPS  = 440;

   typedef struct packed {
      logic [1:0]        status;
      logic signed [31:0] value;
      logic [POS_W-1:0]  position;
      logic [CNT_W-1:0]  count;
   } queue_rsp_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_valid  = 1'b0;
   logic [1:0]         req_func   = cqs_pkg::FUNC_ENQ;
   logic signed [31:0] req_data   = '0;
   logic               rsp_stall  = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_value;
   logic [POS_W-1:0]   rsp_position;
   logic [CNT_W-1:0]   rsp_count;

   // mirror of the queue contents and pointers
   logic signed [31:0] mirror_slot [DEPTH];
   logic [POS_W-1:0]   mirror_head = '0;
   logic [POS_W-1:0]   mirror_tail = '0;
   logic [CNT_W-1:0]   mirror_fill = '0;

   queue_rsp_type pending_rsp[$];
   int  err_count  = 0;
   int  n_sent     = 0;
   int  n_seen     = 0;
   int  status_seen[4] = '{0, 0, 0, 0};
   bit  idle_on    = 1'b1;
   bit  hold_req   = 1'b0;

   circular_queue_with_search_unit #(.DEPTH(DEPTH)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   always #4 clock = ~clock;

   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

   function automatic logic [POS_W-1:0] slot_after(input logic [POS_W-1:0] s);
      return (s == POS_W'(DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   // advances the mirror by one operation and returns the result it causes
   function automatic queue_rsp_type apply_queue_op(input logic [1:0] f,
                                                    input logic signed [31:0] d);
      queue_rsp_type    r;
      logic [POS_W-1:0] s;
      bit               found;
      r = '0;
      r.status = cqs_pkg::ST_OK;
      found = 1'b0;
      case (f)
         cqs_pkg::FUNC_ENQ: begin
            if (mirror_fill == CNT_W'(DEPTH)) begin
               r.status = cqs_pkg::ST_FULL;
            end else begin
               mirror_slot[mirror_tail] = d;
               mirror_tail = slot_after(mirror_tail);
               mirror_fill = mirror_fill + 1'b1;
            end
         end
         cqs_pkg::FUNC_DEQ: begin
            if (mirror_fill == '0) begin
               r.status = cqs_pkg::ST_EMPTY;
            end else begin
               r.value = mirror_slot[mirror_head];
               mirror_fill = mirror_fill - 1'b1;
               // draining the last entry rewinds both pointers to slot 0
               if (mirror_fill == '0) begin
                  mirror_head = '0;
                  mirror_tail = '0;
               end else begin
                  mirror_head = slot_after(mirror_head);
               end
            end
         end
         cqs_pkg::FUNC_SRCH: begin
            if (mirror_fill == '0) begin
               r.status = cqs_pkg::ST_EMPTY;
            end else begin
               s = mirror_head;
               for (int k = 0; k < mirror_fill; k++) begin
                  if (!found && mirror_slot[s] == d) begin
                     found = 1'b1;
                     r.position = s;
                  end
                  s = slot_after(s);
               end
               if (!found) r.status = cqs_pkg::ST_NOTFOUND;
            end
         end
         default: ;
      endcase
      r.count = mirror_fill;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [31:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2, 3: return 32'(signed'($urandom_range(0, 3)) - 1);
         4: return 32'sd42;
         default: return $urandom;
      endcase
   endfunction

   // offers one request and waits for its transfer
   task automatic send_op(input logic [1:0] f, input logic signed [31:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(apply_queue_op(f, d));
      n_sent++;
   endtask

   // random operation; enq_heavy tilts the mix towards a full queue
   task automatic send_random(input bit enq_heavy);
      int               r;
      int               pick;
      logic [1:0]       f;
      logic signed [31:0] d;
      r = $urandom_range(0, 99);
      if (r < 5)                       f = cqs_pkg::FUNC_NOP;
      else if (r < (enq_heavy ? 55 : 25)) f = cqs_pkg::FUNC_ENQ;
      else if (r < 75)                 f = cqs_pkg::FUNC_DEQ;
      else                             f = cqs_pkg::FUNC_SRCH;
      d = pick_word();
      // most searches look for a key that is actually held
      if (f == cqs_pkg::FUNC_SRCH && mirror_fill != '0 && $urandom_range(0, 2) != 0) begin
         pick = (int'(mirror_head) + int'($urandom_range(0, mirror_fill - 1))) % DEPTH;
         d = mirror_slot[POS_W'(pick)];
      end
      send_op(f, d);
   endtask

   task automatic test_extremes();
      send_op(cqs_pkg::FUNC_ENQ, 32'sh8000_0000);
      send_op(cqs_pkg::FUNC_ENQ, 32'sh7fff_ffff);
      send_op(cqs_pkg::FUNC_ENQ, 32'sd0);
      send_op(cqs_pkg::FUNC_ENQ, -32'sd1);
      send_op(cqs_pkg::FUNC_SRCH, 32'sh7fff_ffff);
      send_op(cqs_pkg::FUNC_SRCH, 32'sh8000_0000);
      send_op(cqs_pkg::FUNC_SRCH, 32'sd12345);
      send_op(cqs_pkg::FUNC_NOP, 32'sh5a5a_a5a5);
   endtask

   task automatic test_full_and_wrap();
      send_op(cqs_pkg::FUNC_ENQ, 32'sd0);           // duplicate key, first match wins
      send_op(cqs_pkg::FUNC_ENQ, 32'sd7);
      send_op(cqs_pkg::FUNC_ENQ, 32'sd8);
      send_op(cqs_pkg::FUNC_ENQ, 32'sd9);
      send_op(cqs_pkg::FUNC_ENQ, 32'sd10);          // overflow
      send_op(cqs_pkg::FUNC_SRCH, 32'sd0);
      send_op(cqs_pkg::FUNC_DEQ, 32'sd0);
      send_op(cqs_pkg::FUNC_DEQ, 32'sd0);
      send_op(cqs_pkg::FUNC_ENQ, 32'sd11);          // wraps into slot 0
      send_op(cqs_pkg::FUNC_ENQ, 32'sd12);
      send_op(cqs_pkg::FUNC_SRCH, 32'sd12);
   endtask

   task automatic test_empty_cases();
      repeat (DEPTH) send_op(cqs_pkg::FUNC_DEQ, 32'sd0);
      send_op(cqs_pkg::FUNC_DEQ, 32'sd0);           // underflow
      send_op(cqs_pkg::FUNC_SRCH, 32'sd0);          // search on empty queue
      send_op(cqs_pkg::FUNC_ENQ, 32'sd99);          // lands in slot 0 after drain
      send_op(cqs_pkg::FUNC_SRCH, 32'sd99);
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      idle_on  = 1'b0;
      repeat (24) send_random(1'($urandom_range(0, 1)));
      idle_on  = 1'b1;
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (40) send_random(1'($urandom_range(0, 1)));
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      bit enq_heavy;
      enq_heavy = 1'b1;
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i % 30 == 0) enq_heavy = ~enq_heavy;
         send_random(enq_heavy);
      end
   endtask

   // receiver side stall pattern, with one long hold on request
   initial begin : rsp_stall_gen
      int  run_len;
      logic stall_next;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req   = 1'b0;
            stall_next = 1'b1;
            run_len    = HOLD_CYCLES;
         end else if (!idle_on) begin
            stall_next = 1'b0;
            run_len    = 1;
         end else begin
            stall_next = ($urandom_range(0, 2) == 0);
            run_len    = pick_gap() + 1;
         end
         rsp_stall <= stall_next;
         repeat (run_len) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      queue_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_seen++;
         status_seen[rsp_status]++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected transfer: status %0d value %0d", rsp_status, rsp_value);
            err_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               err_count++;
            end
            if (rsp_value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_value);
               err_count++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               err_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               err_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_full_and_wrap();
      test_empty_cases();
      test_backpressure();
      test_back_to_back();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      $display("covered %0d requests and %0d responses", n_sent, n_seen);
      $display("ok/found %0d, overflow %0d, empty %0d, not found %0d",
               status_seen[cqs_pkg::ST_OK], status_seen[cqs_pkg::ST_FULL],
               status_seen[cqs_pkg::ST_EMPTY], status_seen[cqs_pkg::ST_NOTFOUND]);
      if (err_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
